### hdl/ils_pkg.sv
`timescale 1ns / 1ps
package ils_pkg;

   localparam int MAX_N_DEF     = 64;
   localparam int FRAC_BITS_DEF = 24;

   localparam logic [1:0] OP_LOAD_COEF = 2'd0;
   localparam logic [1:0] OP_LOAD_RHS  = 2'd1;
   localparam logic [1:0] OP_START     = 2'd2;

   localparam logic [1:0] REG_METHOD     = 2'd0;
   localparam logic [1:0] REG_SIZE       = 2'd1;
   localparam logic [1:0] REG_TOLERANCE  = 2'd2;
   localparam logic [1:0] REG_MAX_SWEEPS = 2'd3;

   typedef struct packed {
      logic [1:0]         op;
      logic [5:0]         row;
      logic [5:0]         col;
      logic signed [31:0] value;
   } ils_req_type;

   typedef struct packed {
      logic [5:0]         index;
      logic signed [31:0] solution;
      logic [15:0]        sweeps;
      logic               converged;
      logic               last;
   } ils_rsp_type;

   // ring control shared by all cells
   typedef struct packed {
      logic clear;
      logic shift;
      logic copy;
   } ils_cell_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIAG,
      ST_DIAGW,
      ST_ELEM,
      ST_ELEMW,
      ST_DIVW,
      ST_RHS,
      ST_RHSW,
      ST_RHSDIV,
      ST_CHECK,
      ST_ROW,
      ST_FIN,
      ST_ENDSW,
      ST_OUT
   } ils_state_type;

endpackage

### hdl/ils_div.sv
`timescale 1ns / 1ps
module ils_div #(
   parameter int FRAC_BITS = ils_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] num,
   input  logic signed [32:0] den,
   output logic               busy,
   output logic               done,
   output logic signed [31:0] quot
);
   import ils_pkg::*;

   localparam int NW = 32 + FRAC_BITS;
   localparam int KW = $clog2(NW + 1);

   logic          busy_ff, done_ff;
   logic [KW-1:0] cnt_ff;
   logic [NW-1:0] nmag_ff, q_ff;
   logic [31:0]   rem_ff;
   logic [32:0]   dmag_ff;
   logic          neg_ff, zero_ff;

   logic [31:0]   num_abs;
   logic [32:0]   den_abs, trial;
   logic          fits;

   assign num_abs = num[31] ? 32'(-num) : 32'(num);
   assign den_abs = den[32] ? 33'(-den) : 33'(den);
   assign trial   = {rem_ff, nmag_ff[NW-1]};
   assign fits    = trial >= dmag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == KW'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // restoring division, one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (start) begin
         nmag_ff <= {num_abs, FRAC_BITS'(0)};
         dmag_ff <= den_abs;
         rem_ff  <= '0;
         q_ff    <= '0;
         cnt_ff  <= KW'(NW);
         neg_ff  <= num[31] ^ den[32];
         zero_ff <= (den == '0);
      end else if (busy_ff) begin
         rem_ff  <= fits ? 32'(trial - dmag_ff) : trial[31:0];
         q_ff    <= {q_ff[NW-2:0], fits};
         nmag_ff <= {nmag_ff[NW-2:0], 1'b0};
         cnt_ff  <= cnt_ff - KW'(1);
      end
   end

   always_comb begin
      if (zero_ff) begin
         quot = '0;
      end else if (!neg_ff) begin
         quot = (q_ff[NW-1:31] != '0) ? 32'sh7fffffff : $signed(q_ff[31:0]);
      end else if (q_ff[NW-1:32] != '0 || (q_ff[31] && q_ff[30:0] != '0)) begin
         quot = 32'sh80000000;
      end else begin
         quot = $signed(32'(-q_ff[31:0]));
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;

endmodule

### hdl/ils_cell.sv
`timescale 1ns / 1ps
module ils_cell (
   input  logic                       clock,
   input  ils_pkg::ils_cell_ctrl_type ctrl,
   input  logic                       load,
   input  logic signed [31:0]         load_value,
   input  logic signed [31:0]         nb_old,
   input  logic signed [31:0]         nb_new,
   output logic signed [31:0]         old_value,
   output logic signed [31:0]         new_value
);
   import ils_pkg::*;

   logic signed [31:0] old_ff, new_ff;

   always_ff @(posedge clock) begin
      priority if (ctrl.clear) begin
         old_ff <= '0;
         new_ff <= '0;
      end else if (ctrl.shift) begin
         old_ff <= nb_old;
         new_ff <= nb_new;
      end else if (load) begin
         new_ff <= load_value;
      end else if (ctrl.copy) begin
         old_ff <= new_ff;
      end
   end

   assign old_value = old_ff;
   assign new_value = new_ff;

endmodule

### hdl/iterative_linear_solver.sv
`timescale 1ns / 1ps
// Iterative linear solver (Jacobi or Gauss-Seidel), signed fixed point.
// Input channel req_*: one transfer per cycle loads a coefficient A[row][col]
// or a right-hand value B[row]; a start transfer launches a solve. req_ready
// is high only while the block is idle, so loads go at one per cycle.
// Output channel rsp_*: after a solve, n transfers carry solution elements
// 0..n-1 with the sweep count and converged flag; last marks element n-1.
// A start first scales the rows: one serial divider runs over the off-diagonal
// coefficients and right-hand values of each row, one at a time; each sweep then
// passes every row through the whole ring of MAX_N cells and the
// multiply-accumulate pipeline. Results leave at up to one per cycle.
// The solution lives in a ring of cells that rotates one place a cycle while a row
// is issued and one place per rsp transfer; the head cell feeds the multiplier and the output.
// Synchronous reset returns the configuration registers to their defaults and the control
// to idle; loaded coefficients stay undefined until written.
// When the receiver stalls, hold the current element; the ring rotates only
// on a completed rsp transfer.
module iterative_linear_solver #(
   parameter int MAX_N     = ils_pkg::MAX_N_DEF,
   parameter int FRAC_BITS = ils_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ils_pkg::ils_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ils_pkg::ils_rsp_type rsp_data,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [30:0]          csr_wdata
);
   import ils_pkg::*;

   localparam int IW = $clog2(MAX_N);
   localparam int AW = 2 * IW;
   localparam int CW = $clog2(MAX_N + 3);

   // configuration
   logic        method_ff;
   logic [6:0]  size_ff;
   logic [30:0] tol_ff;
   logic [15:0] max_ff;

   // control
   ils_state_type state_ff, state_in;
   logic [IW-1:0] i_ff, i_in, j_ff, j_in, nm1_ff, nm1_in;
   logic [CW-1:0] c_ff, c_in;
   logic signed [31:0] d_ff, d_in;
   logic [31:0] worst_ff, worst_in, largest_ff, largest_in;
   logic [15:0] sweep_ff, sweep_in;

   // memories
   logic signed [31:0] coef_mem [1 << AW];
   logic signed [31:0] scl_mem  [1 << AW];
   logic signed [31:0] rhs_mem  [1 << IW];
   logic signed [31:0] coef_rd_ff, scl_rd_ff, rhs_rd_ff;
   logic [AW-1:0] coef_raddr, scl_raddr, scl_waddr;
   logic          scl_we;
   logic signed [31:0] scl_wdata;

   // multiply-accumulate pipeline
   logic               v1_ff, v1_in, dg1_ff, dg1_in, v2_ff;
   logic signed [31:0] x1_ff, x1_in, oldi_ff, oldi_in;
   logic signed [63:0] prod_ff, prod_in, acc_ff, acc_in, off_ext;

   // divider
   logic               div_start, div_busy, div_done;
   logic signed [31:0] div_num, div_q;
   logic signed [32:0] div_den;

   // ring
   ils_cell_ctrl_type  ring_ctrl;
   logic signed [31:0] cold [MAX_N];
   logic signed [31:0] cnew [MAX_N];
   logic signed [31:0] newv;
   logic signed [32:0] dif;
   logic [31:0]        mag;

   logic req_fire, rsp_fire, row_issue;
   logic [IW-1:0] row_ix, col_ix, cj;
   int size_clamped;

   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign row_ix    = IW'(req_data.row);
   assign col_ix    = IW'(req_data.col);
   assign cj        = IW'(c_ff);
   assign row_issue = (state_ff == ST_ROW) && (c_ff < CW'(MAX_N));

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         method_ff <= 1'b0;
         size_ff   <= 7'd1;
         tol_ff    <= 31'd168;
         max_ff    <= 16'd1000;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_METHOD:     method_ff <= csr_wdata[0];
            REG_SIZE:       size_ff   <= csr_wdata[6:0];
            REG_TOLERANCE:  tol_ff    <= csr_wdata;
            REG_MAX_SWEEPS: max_ff    <= csr_wdata[15:0];
            default:        ;
         endcase
      end
   end

   // load memories: written on load transfers, read data registered
   always_ff @(posedge clock) begin
      if (req_fire && req_data.op == OP_LOAD_COEF &&
          int'(req_data.row) < MAX_N && int'(req_data.col) < MAX_N) begin
         coef_mem[{row_ix, col_ix}] <= req_data.value;
      end
      coef_rd_ff <= coef_mem[coef_raddr];
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_data.op == OP_LOAD_RHS && int'(req_data.row) < MAX_N) begin
         rhs_mem[row_ix] <= req_data.value;
      end
      rhs_rd_ff <= rhs_mem[i_ff];
   end

   // scaled rows; the diagonal slot holds the row offset B[i]/A[i][i]
   always_ff @(posedge clock) begin
      if (scl_we) begin
         scl_mem[scl_waddr] <= scl_wdata;
      end
      scl_rd_ff <= scl_mem[scl_raddr];
   end

   assign coef_raddr = (state_ff == ST_DIAG) ? {i_ff, i_ff} : {i_ff, j_ff};
   assign scl_raddr  = {i_ff, cj};

   ils_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_q)
   );

   // ring of cells; cell k takes from cell k+1, the head is cell 0
   for (genvar k = 0; k < MAX_N; k++) begin : g_ring
      ils_cell u_cell (
         .clock      (clock),
         .ctrl       (ring_ctrl),
         .load       ((state_ff == ST_FIN) && (i_ff == IW'(k))),
         .load_value (newv),
         .nb_old     (cold[(k + 1) % MAX_N]),
         .nb_new     (cnew[(k + 1) % MAX_N]),
         .old_value  (cold[k]),
         .new_value  (cnew[k])
      );
   end

   // row sum saturation and change magnitude
   always_comb begin
      if (!acc_ff[63] && acc_ff[62:31] != '0) begin
         newv = 32'sh7fffffff;
      end else if (acc_ff[63] && acc_ff[62:31] != '1) begin
         newv = 32'sh80000000;
      end else begin
         newv = acc_ff[31:0];
      end
      dif = 33'(newv) - 33'(oldi_ff);
      mag = dif[32] ? 32'(-dif) : 32'(dif);
   end

   // multiply-accumulate datapath
   always_comb begin
      v1_in   = row_issue && (cj <= nm1_ff);
      dg1_in  = cj == i_ff;
      x1_in   = (method_ff && cj < i_ff) ? cnew[0] : cold[0];
      off_ext = 64'(scl_rd_ff);
      prod_in = dg1_ff ? (off_ext <<< FRAC_BITS) : scl_rd_ff * x1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      dg1_ff  <= dg1_in;
      x1_ff   <= x1_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      oldi_ff <= oldi_in;
      d_ff    <= d_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         i_ff       <= '0;
         j_ff       <= '0;
         c_ff       <= '0;
         nm1_ff     <= '0;
         worst_ff   <= '0;
         largest_ff <= '1;
         sweep_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         i_ff       <= i_in;
         j_ff       <= j_in;
         c_ff       <= c_in;
         nm1_ff     <= nm1_in;
         worst_ff   <= worst_in;
         largest_ff <= largest_in;
         sweep_ff   <= sweep_in;
      end
   end

   // next state and control
   always_comb begin
      state_in   = state_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      c_in       = c_ff;
      nm1_in     = nm1_ff;
      d_in       = d_ff;
      worst_in   = worst_ff;
      largest_in = largest_ff;
      sweep_in   = sweep_ff;
      acc_in     = v2_ff ? acc_ff + (prod_ff >>> FRAC_BITS) : acc_ff;
      oldi_in    = (row_issue && cj == i_ff) ? cold[0] : oldi_ff;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      div_start  = 1'b0;
      div_num    = coef_rd_ff;
      div_den    = -{d_ff[31], d_ff};
      scl_we     = 1'b0;
      scl_waddr  = {i_ff, j_ff};
      scl_wdata  = div_q;
      ring_ctrl  = '0;
      size_clamped = int'(size_ff);
      if (size_clamped < 1) size_clamped = 1;
      if (size_clamped > MAX_N) size_clamped = MAX_N;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_data.op == OP_START) begin
               nm1_in         = IW'(size_clamped - 1);
               ring_ctrl.clear = 1'b1;
               largest_in     = '1;
               sweep_in       = '0;
               i_in           = '0;
               state_in       = ST_DIAG;
            end
         end
         ST_DIAG:  state_in = ST_DIAGW;
         ST_DIAGW: begin
            d_in     = coef_rd_ff;
            j_in     = '0;
            state_in = ST_ELEM;
         end
         ST_ELEM: begin
            // skip the diagonal; its slot gets the offset
            if (j_ff == i_ff) begin
               if (j_ff == nm1_ff) begin
                  state_in = ST_RHS;
               end else begin
                  j_in = j_ff + IW'(1);
               end
            end else begin
               state_in = ST_ELEMW;
            end
         end
         ST_ELEMW: begin
            div_start = 1'b1;
            state_in  = ST_DIVW;
         end
         ST_DIVW: begin
            if (div_done) begin
               scl_we = 1'b1;
               if (j_ff == nm1_ff) begin
                  state_in = ST_RHS;
               end else begin
                  j_in     = j_ff + IW'(1);
                  state_in = ST_ELEM;
               end
            end
         end
         ST_RHS:  state_in = ST_RHSW;
         ST_RHSW: begin
            div_start = 1'b1;
            div_num   = rhs_rd_ff;
            div_den   = {d_ff[31], d_ff};
            state_in  = ST_RHSDIV;
         end
         ST_RHSDIV: begin
            scl_waddr = {i_ff, i_ff};
            if (div_done) begin
               scl_we = 1'b1;
               if (i_ff == nm1_ff) begin
                  state_in = ST_CHECK;
               end else begin
                  i_in     = i_ff + IW'(1);
                  state_in = ST_DIAG;
               end
            end
         end
         ST_CHECK: begin
            if (largest_ff > {1'b0, tol_ff} && sweep_ff < max_ff) begin
               i_in     = '0;
               c_in     = '0;
               acc_in   = '0;
               worst_in = '0;
               state_in = ST_ROW;
            end else begin
               j_in     = '0;
               state_in = ST_OUT;
            end
         end
         ST_ROW: begin
            // rotate a full turn, then drain the pipeline
            ring_ctrl.shift = row_issue;
            c_in = c_ff + CW'(1);
            if (c_ff == CW'(MAX_N + 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (mag > worst_ff) worst_in = mag;
            if (i_ff == nm1_ff) begin
               state_in = ST_ENDSW;
            end else begin
               i_in     = i_ff + IW'(1);
               c_in     = '0;
               acc_in   = '0;
               state_in = ST_ROW;
            end
         end
         ST_ENDSW: begin
            ring_ctrl.copy = 1'b1;
            largest_in     = worst_ff;
            sweep_in       = sweep_ff + 16'd1;
            state_in       = ST_CHECK;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               ring_ctrl.shift = 1'b1;
               if (j_ff == nm1_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  j_in = j_ff + IW'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_data.index     = 6'(j_ff);
   assign rsp_data.solution  = cold[0];
   assign rsp_data.sweeps    = sweep_ff;
   assign rsp_data.converged = largest_ff <= {1'b0, tol_ff};
   assign rsp_data.last      = j_ff == nm1_ff;

`ifndef ASSERT_OFF
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input accepted while results pending");

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   a_sweep_cap: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> sweep_ff <= max_ff)
      else $error("sweep count beyond cap");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_data.last |=> req_ready)
      else $error("not idle after last result");
`endif

endmodule
